### rtl/cmpr_tiled_block_texture_decode_core_assert.svh
// Assertion macros for the tiled block texture decoder checker.
// No dependencies; expects i_clk and i_rst_n in the scope of use.
`ifndef CMPR_TILED_BLOCK_TEXTURE_DECODE_CORE_ASSERT_SVH
`define CMPR_TILED_BLOCK_TEXTURE_DECODE_CORE_ASSERT_SVH

// Checked only while out of reset
`define CTBTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define CTBTD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/ctbtd_pkg.sv
// Shared constants, payload types and work-queue entry of the tiled block decoder.
// No dependencies.
`default_nettype none

package ctbtd_pkg;

    // Largest image side in pixels
    localparam int MAX_DIM = 1024;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = CFG_W'(MAX_DIM);

    // Derived widths
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int TILE_W  = (COORD_W > 3) ? COORD_W - 3 : 1;
    localparam int BASE_W  = TILE_W + 3;
    localparam int TCNT_W  = TILE_W + 1;
    localparam int CLAMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam int PIX_W   = 10;
    localparam int XW_A    = (BASE_W + 1 > DIM_W) ? BASE_W + 1 : DIM_W;
    localparam int XW      = (XW_A > PIX_W) ? XW_A : PIX_W;

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] color_a;
        logic [15:0] color_b;
        logic [31:0] index_word;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             last;
    } t_out_item;

    // One visible sub-block, palette already built
    typedef struct packed {
        logic [3:0][15:0]  pal;
        logic [31:0]       index_word;
        logic [BASE_W-1:0] base_x;
        logic [BASE_W-1:0] base_y;
        logic [1:0]        last_col;
        logic [1:0]        last_row;
    } t_work;

endpackage

`default_nettype wire

### rtl/ctbtd_front.sv
// Front end: configuration registers, tile position tracking, palette build and
// visibility classification of each sub-block. Depends on ctbtd_pkg.
`default_nettype none

module ctbtd_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    input  wire [ctbtd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [ctbtd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                            i_accept,
    input  ctbtd_pkg::t_in_item            i_item,
    output logic                           o_push,
    output ctbtd_pkg::t_work               o_work
);
    import ctbtd_pkg::*;

    logic [CFG_W-1:0]  r_image_width, n_image_width;
    logic [CFG_W-1:0]  r_image_height, n_image_height;
    logic [1:0]        r_sub, n_sub;
    logic [TILE_W-1:0] r_tile_col, n_tile_col;
    logic [TILE_W-1:0] r_tile_row, n_tile_row;

    logic [DIM_W-1:0]  w_width, w_height;
    logic [DIM_W:0]    w_tsum_x, w_tsum_y;
    logic [TCNT_W-1:0] w_tiles_x, w_tiles_y;
    logic [TCNT_W-1:0] w_col_inc, w_row_inc;
    logic [BASE_W-1:0] w_base_x, w_base_y;
    logic [3:0]        w_col_ok, w_row_ok;
    logic [1:0]        w_last_col, w_last_row;
    logic              w_gt;
    logic [15:0]       w_pal2, w_pal3;

    // Clamp a programmed dimension into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] f_clamp(input logic [CFG_W-1:0] v);
        logic [CLAMP_W-1:0] e;
        e = CLAMP_W'(v);
        priority if (e == '0) begin
            return DIM_W'(1);
        end else if (e > CLAMP_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return e[DIM_W-1:0];
        end
    endfunction

    // s / 3 for s below 192, by reciprocal
    function automatic logic [5:0] f_div3(input logic [7:0] s);
        logic [15:0] prod;
        prod = 16'(s) * 16'd171;
        return prod[14:9];
    endfunction

    // (2a + b) / 3 per channel, truncated
    function automatic logic [15:0] f_third(input logic [15:0] ca, input logic [15:0] cb);
        logic [7:0] sr, sg, sb;
        logic [5:0] qr, qg, qb;
        sr = {2'b00, ca[15:11], 1'b0} + {3'b000, cb[15:11]};
        sg = {1'b0, ca[10:5], 1'b0} + {2'b00, cb[10:5]};
        sb = {2'b00, ca[4:0], 1'b0} + {3'b000, cb[4:0]};
        qr = f_div3(sr);
        qg = f_div3(sg);
        qb = f_div3(sb);
        return {qr[4:0], qg, qb[4:0]};
    endfunction

    // (a + b) / 2 per channel, truncated
    function automatic logic [15:0] f_half(input logic [15:0] ca, input logic [15:0] cb);
        logic [5:0] sr, sb;
        logic [6:0] sg;
        sr = {1'b0, ca[15:11]} + {1'b0, cb[15:11]};
        sg = {1'b0, ca[10:5]} + {1'b0, cb[10:5]};
        sb = {1'b0, ca[4:0]} + {1'b0, cb[4:0]};
        return {sr[5:1], sg[6:1], sb[5:1]};
    endfunction

    // Effective dimensions and tile counts
    always_comb begin
        w_width   = f_clamp(r_image_width);
        w_height  = f_clamp(r_image_height);
        w_tsum_x  = {1'b0, w_width} + (DIM_W + 1)'(7);
        w_tsum_y  = {1'b0, w_height} + (DIM_W + 1)'(7);
        w_tiles_x = TCNT_W'(w_tsum_x >> 3);
        w_tiles_y = TCNT_W'(w_tsum_y >> 3);
        w_col_inc = {1'b0, r_tile_col} + TCNT_W'(1);
        w_row_inc = {1'b0, r_tile_row} + TCNT_W'(1);
    end

    // Sub-block origin and which rows and columns fall inside the image
    always_comb begin
        w_base_x = {r_tile_col, r_sub[0], 2'b00};
        w_base_y = {r_tile_row, r_sub[1], 2'b00};
        for (int c = 0; c < 4; c++) begin
            w_col_ok[c] = (XW'(w_base_x) + XW'(c)) < XW'(w_width);
            w_row_ok[c] = (XW'(w_base_y) + XW'(c)) < XW'(w_height);
        end
        priority if (w_col_ok[3]) w_last_col = 2'd3;
        else if (w_col_ok[2])     w_last_col = 2'd2;
        else if (w_col_ok[1])     w_last_col = 2'd1;
        else                      w_last_col = 2'd0;
        priority if (w_row_ok[3]) w_last_row = 2'd3;
        else if (w_row_ok[2])     w_last_row = 2'd2;
        else if (w_row_ok[1])     w_last_row = 2'd1;
        else                      w_last_row = 2'd0;
    end

    // Palette
    always_comb begin
        w_gt = i_item.color_a > i_item.color_b;
        if (w_gt) begin
            w_pal2 = f_third(i_item.color_a, i_item.color_b);
            w_pal3 = f_third(i_item.color_b, i_item.color_a);
        end else begin
            w_pal2 = f_half(i_item.color_a, i_item.color_b);
            w_pal3 = 16'h0000;
        end
    end

    // Work entry; sub-blocks wholly outside the image are dropped here
    always_comb begin
        o_work.pal[0]     = i_item.color_a;
        o_work.pal[1]     = i_item.color_b;
        o_work.pal[2]     = w_pal2;
        o_work.pal[3]     = w_pal3;
        o_work.index_word = i_item.index_word;
        o_work.base_x     = w_base_x;
        o_work.base_y     = w_base_y;
        o_work.last_col   = w_last_col;
        o_work.last_row   = w_last_row;
        o_push            = i_accept && w_col_ok[0] && w_row_ok[0];
    end

    // Configuration writes
    always_comb begin
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_image_width  = i_cfg_data;
                CFG_IMAGE_HEIGHT: n_image_height = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Position advance: 2x2 inside the tile, tiles left to right, then rows
    always_comb begin
        n_sub      = r_sub;
        n_tile_col = r_tile_col;
        n_tile_row = r_tile_row;
        if (i_accept) begin
            n_sub = r_sub + 2'd1;
            if (r_sub == 2'd3) begin
                if (w_col_inc >= w_tiles_x) begin
                    n_tile_col = '0;
                    if (w_row_inc >= w_tiles_y) begin
                        n_tile_row = '0;
                    end else begin
                        n_tile_row = w_row_inc[TILE_W-1:0];
                    end
                end else begin
                    n_tile_col = w_col_inc[TILE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_DIM_RESET;
            r_image_height <= CFG_DIM_RESET;
            r_sub          <= '0;
            r_tile_col     <= '0;
            r_tile_row     <= '0;
        end else begin
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_sub          <= n_sub;
            r_tile_col     <= n_tile_col;
            r_tile_row     <= n_tile_row;
        end
    end

endmodule

`default_nettype wire

### rtl/ctbtd_queue.sv
// Short work queue between the front end and the pixel back end.
// Depends on ctbtd_pkg.
`default_nettype none

module ctbtd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  ctbtd_pkg::t_work    i_wdata,
    output logic                o_full,
    input  wire                 i_pop,
    output ctbtd_pkg::t_work    o_rdata,
    output logic                o_empty
);
    import ctbtd_pkg::*;

    t_work              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               w_do_push, w_do_pop;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    // Status and pointer update
    always_comb begin
        o_full    = r_count == QCNT_W'(QUEUE_DEPTH);
        o_empty   = r_count == '0;
        o_rdata   = r_mem[r_rd_ptr];
        w_do_push = i_push && !o_full;
        w_do_pop  = i_pop && !o_empty;
        n_wr_ptr  = w_do_push ? f_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr  = w_do_pop ? f_next(r_rd_ptr) : r_rd_ptr;
        n_count   = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/ctbtd_back.sv
// Back end: walks the visible pixels of the head sub-block into the result register,
// one per cycle while that register is free or being drained. Depends on ctbtd_pkg.
`default_nettype none

module ctbtd_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_avail,
    input  ctbtd_pkg::t_work     i_work,
    output logic                 o_take,
    output logic                 o_empty,
    input  wire                  i_pop,
    output ctbtd_pkg::t_out_item o_result
);
    import ctbtd_pkg::*;

    logic [1:0]  r_col, n_col;
    logic [1:0]  r_row, n_row;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out;

    logic        w_fire;
    logic        w_end_col, w_end_row;
    logic [4:0]  w_shamt;
    logic [31:0] w_shifted;
    logic [15:0] w_raw;
    logic [XW-1:0] w_x, w_y;
    t_out_item   w_pixel;

    // Current pixel
    always_comb begin
        w_end_col = r_col == i_work.last_col;
        w_end_row = r_row == i_work.last_row;
        w_shamt   = {r_row, r_col, 1'b0};
        w_shifted = i_work.index_word << w_shamt;
        w_raw     = i_work.pal[w_shifted[31:30]];
        w_x       = XW'(i_work.base_x) + XW'(r_col);
        w_y       = XW'(i_work.base_y) + XW'(r_row);
        w_pixel.pixel_x = w_x[PIX_W-1:0];
        w_pixel.pixel_y = w_y[PIX_W-1:0];
        w_pixel.red     = {w_raw[15:11], 3'b000};
        w_pixel.green   = {w_raw[10:6], 3'b000};
        w_pixel.blue    = {w_raw[4:0], 3'b000};
        w_pixel.last    = w_end_col && w_end_row;
    end

    // Issue a pixel whenever the result register is free or being drained
    always_comb begin
        w_fire      = i_avail && (!r_out_valid || i_pop);
        o_take      = w_fire && w_end_col && w_end_row;
        n_col       = r_col;
        n_row       = r_row;
        n_out_valid = r_out_valid;
        if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (w_fire) begin
            n_out_valid = 1'b1;
            if (w_end_col) begin
                n_col = '0;
                n_row = w_end_row ? 2'd0 : r_row + 2'd1;
            end else begin
                n_col = r_col + 2'd1;
            end
        end
    end

    always_comb begin
        o_empty  = !r_out_valid;
        o_result = r_out;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/cmpr_tiled_block_texture_decode_core.sv
// The first pixel of a sub-block passes through the work queue and the result register
// before it reaches the result ports; the rest follow one per cycle while pop is held high.
// Pixels: a sub-block yields as many as it has inside the image (up to 16); one wholly
// outside the image is dropped at the input and never queued. Input
// stalls only while the two-entry work queue is full. Reset (synchronous, active low)
// empties queue and result register, sets both sides to 1024 and the position to zero.
`default_nettype none

module cmpr_tiled_block_texture_decode_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_push,
    output logic                           o_full,
    input  ctbtd_pkg::t_in_item            i_item,
    output logic                           o_empty,
    input  wire                            i_pop,
    output ctbtd_pkg::t_out_item           o_result,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [ctbtd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [ctbtd_pkg::CFG_W-1:0]     i_cfg_data
);
    import ctbtd_pkg::*;

    logic  w_accept;
    logic  w_q_push, w_q_full, w_q_pop, w_q_empty;
    t_work w_q_wdata, w_q_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_full      = w_q_full;
    assign w_accept    = i_push && !w_q_full;

    // Front: position, palette and classification
    ctbtd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .o_push      (w_q_push),
        .o_work      (w_q_wdata)
    );

    // Decoupling queue
    ctbtd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_wdata (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_rdata (w_q_rdata),
        .o_empty (w_q_empty)
    );

    // Back: pixel emission
    ctbtd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (!w_q_empty),
        .i_work   (w_q_rdata),
        .o_take   (w_q_pop),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

### rtl/ctbtd_checker.sv
// Port-level checker for the tiled block texture decoder, bound to the top level.
// Depends on ctbtd_pkg and the assertion macro header.
`default_nettype none

`include "cmpr_tiled_block_texture_decode_core_assert.svh"

module ctbtd_port_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            o_full,
    input  wire                            o_empty,
    input  wire                            i_pop,
    input  ctbtd_pkg::t_out_item           o_result,
    input  wire                            i_cfg_valid,
    input  wire                            o_cfg_ready,
    input  wire [ctbtd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [ctbtd_pkg::CFG_W-1:0]     i_cfg_data
);
    import ctbtd_pkg::*;

    logic [CFG_W-1:0] r_width, r_height;
    logic             w_x_ok, w_y_ok, w_in_image;

    // Shadow of the programmed dimensions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_DIM_RESET;
            r_height <= CFG_DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
        end
    end

    // Emitted pixel lies inside the clamped image
    always_comb begin
        w_x_ok = (r_width == '0) ? (o_result.pixel_x == '0)
                                 : (CFG_W'(o_result.pixel_x) < r_width);
        w_y_ok = (r_height == '0) ? (o_result.pixel_y == '0)
                                  : (CFG_W'(o_result.pixel_y) < r_height);
        w_in_image = w_x_ok && w_y_ok;
    end

    // Reset leaves both sides idle
    `CTBTD_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> o_empty && !o_full, "not idle after reset")

    // A waiting result holds until taken
    `CTBTD_ASSERT(a_result_hold, !o_empty && !i_pop |=> !o_empty && $stable(o_result), "result changed while stalled")

    // A sub-block's pixels come without gaps once the first is out
    `CTBTD_ASSERT(a_no_gap, !o_empty && i_pop && !o_result.last |=> !o_empty, "gap inside a sub-block")

    // Coordinates stay within the programmed image
    `CTBTD_ASSERT(a_in_image, !o_empty |-> w_in_image, "pixel outside the image")

endmodule

bind cmpr_tiled_block_texture_decode_core ctbtd_port_checker u_ctbtd_checker (.*);

`default_nettype wire
